@@ rtl/ultrasonic_tcg_wall_gate_unit_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the TCG / wall gate unit
// Checks compile in simulation only; synthesis sees empty macros.
// ----------------------------------------------------------------------------
`ifndef ULTRASONIC_TCG_WALL_GATE_UNIT_MACROS_SVH
`define ULTRASONIC_TCG_WALL_GATE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// check that is masked while reset is asserted
`define UTGW_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("utgw: check failed");
// check that also runs through reset
`define UTGW_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("utgw: check failed");
`else
`define UTGW_ASSERT(lbl, clk, rst_n, prop)
`define UTGW_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

@@ rtl/utgw_pkg.sv @@
// ----------------------------------------------------------------------------
// utgw_pkg
// Shared types and constants of the TCG / wall gate unit.
// ----------------------------------------------------------------------------
package utgw_pkg;

    localparam int AMP_BITS     = 16;
    localparam int SAMPLE_W     = 12;
    localparam int ELEM_W       = 8;
    localparam int GAIN_W       = 24;
    localparam int MAX_SAMPLES  = 4096;
    localparam int MAX_ELEMENTS = 256;
    localparam int CLIP_W       = 15;
    localparam int INV_W        = 31;
    localparam int THR_W        = 15;
    localparam int MODE_W       = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 31;

    localparam int MID_DEPTH    = 4;
    localparam int MID_CNT_W    = $clog2(MID_DEPTH + 1);
    localparam int OUT_DEPTH    = 8;
    localparam int OUT_CNT_W    = $clog2(OUT_DEPTH + 1);

    localparam logic [GAIN_W-1:0] UNITY_GAIN = 24'd65536;

    // item commands
    localparam logic CMD_SAMPLE     = 1'b0;
    localparam logic CMD_GAIN_WRITE = 1'b1;

    // gate markers
    localparam logic [1:0] GATE_NONE  = 2'd0;
    localparam logic [1:0] GATE_FRONT = 2'd1;
    localparam logic [1:0] GATE_BACK  = 2'd2;

    // gate_mode bits
    localparam int MODE_RELATIVE = 0;
    localparam int MODE_SHOW_FW  = 1;

    // configuration register indexes
    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_CLIP_LIMIT   = 3'd0;
    localparam t_cfg_idx CFG_INV_FULL     = 3'd1;
    localparam t_cfg_idx CFG_FRONT_THR    = 3'd2;
    localparam t_cfg_idx CFG_BACK_THR     = 3'd3;
    localparam t_cfg_idx CFG_SKIP         = 3'd4;
    localparam t_cfg_idx CFG_MAX_DEPTH    = 3'd5;
    localparam t_cfg_idx CFG_GATE_MODE    = 3'd6;

    typedef struct packed {
        logic                       cmd;
        logic signed [AMP_BITS-1:0] amplitude;
        logic                       last_in_scan;
        logic                       last_in_frame;
        logic [SAMPLE_W-1:0]        table_index;
        logic [GAIN_W-1:0]          gain_value;
    } t_in_item;

    typedef struct packed {
        logic [ELEM_W-1:0]   element_index;
        logic [SAMPLE_W-1:0] sample_index;
        logic signed [15:0]  norm_amplitude;
        logic [1:0]          gate_kind;
        logic [SAMPLE_W-1:0] gated_depth;
    } t_out_item;

    typedef struct packed {
        logic [CLIP_W-1:0]   clip_limit;
        logic [INV_W-1:0]    inv_full_scale;
        logic [THR_W-1:0]    front_threshold;
        logic [THR_W-1:0]    back_threshold;
        logic [SAMPLE_W-1:0] skip_samples;
        logic [SAMPLE_W-1:0] max_depth_samples;
        logic [MODE_W-1:0]   gate_mode;
    } t_cfg;

    typedef struct packed {
        logic [ELEM_W-1:0]   element_index;
        logic [SAMPLE_W-1:0] sample_index;
        logic                scan_end;
    } t_meta;

    typedef struct packed {
        t_meta                      meta;
        logic signed [AMP_BITS-1:0] amplitude;
        logic [GAIN_W-1:0]          gain_value;
    } t_mid_item;

endpackage

@@ rtl/ultrasonic_tcg_wall_gate_unit.sv @@
// ----------------------------------------------------------------------------
// ultrasonic_tcg_wall_gate_unit
// A-scan samples go in through a queue-style push port and gained,
// normalized Q2.14 points with a front/back wall marker come out through a
// queue-style pop port, one result per sample, none for gain table writes.
// The unit sustains one item per clock while full is low: the front end
// fetches the sample's gain from a 4096-entry table with a registered read,
// and the back end is a five-stage pipeline (gain multiply, truncate, clip,
// normalize multiply, saturate) whose last stage gates against the walls.
// full rises when the 4-entry queue between the two halves backs up, which
// happens only while the 8-entry result queue is not drained. Configuration
// writes are always taken and belong in idle periods only.
// ----------------------------------------------------------------------------
module ultrasonic_tcg_wall_gate_unit (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  utgw_pkg::t_in_item                 i_in,
    output logic                               empty,
    input  logic                               pop,
    output utgw_pkg::t_out_item                o_out,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [utgw_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [utgw_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import utgw_pkg::*;

    t_cfg                     r_cfg;

    logic                     w_q_wr;
    t_mid_item                w_q_wdata;
    logic                     w_q_rd;
    logic [$bits(t_mid_item)-1:0] w_q_rdata;
    logic                     w_q_empty;
    logic [MID_CNT_W-1:0]     w_q_count;
    logic                     w_out_wr;
    t_out_item                w_out_wdata;
    logic [$bits(t_out_item)-1:0] w_out_rdata;
    logic [OUT_CNT_W-1:0]     w_out_count;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.clip_limit        <= 15'd22937;
            r_cfg.inv_full_scale    <= 31'd32769;
            r_cfg.front_threshold   <= 15'd3277;
            r_cfg.back_threshold    <= 15'd11469;
            r_cfg.skip_samples      <= 12'd220;
            r_cfg.max_depth_samples <= 12'd576;
            r_cfg.gate_mode         <= 2'd1;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_CLIP_LIMIT: r_cfg.clip_limit        <= i_cfg_data[CLIP_W-1:0];
                CFG_INV_FULL:   r_cfg.inv_full_scale    <= i_cfg_data[INV_W-1:0];
                CFG_FRONT_THR:  r_cfg.front_threshold   <= i_cfg_data[THR_W-1:0];
                CFG_BACK_THR:   r_cfg.back_threshold    <= i_cfg_data[THR_W-1:0];
                CFG_SKIP:       r_cfg.skip_samples      <= i_cfg_data[SAMPLE_W-1:0];
                CFG_MAX_DEPTH:  r_cfg.max_depth_samples <= i_cfg_data[SAMPLE_W-1:0];
                CFG_GATE_MODE:  r_cfg.gate_mode         <= i_cfg_data[MODE_W-1:0];
                default: begin
                end
            endcase
        end
    end

    utgw_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_in      (i_in),
        .i_q_count (w_q_count),
        .o_full    (full),
        .o_q_wr    (w_q_wr),
        .o_q_item  (w_q_wdata)
    );

    utgw_fifo #(
        .WIDTH ($bits(t_mid_item)),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_q_wr),
        .i_wdata (w_q_wdata),
        .i_rd    (w_q_rd),
        .o_rdata (w_q_rdata),
        .o_empty (w_q_empty),
        .o_count (w_q_count)
    );

    utgw_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (r_cfg),
        .i_q_valid   (!w_q_empty),
        .i_q_item    (t_mid_item'(w_q_rdata)),
        .o_q_rd      (w_q_rd),
        .i_out_count (w_out_count),
        .o_out_wr    (w_out_wr),
        .o_out_item  (w_out_wdata)
    );

    utgw_fifo #(
        .WIDTH ($bits(t_out_item)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (w_out_wr),
        .i_wdata (w_out_wdata),
        .i_rd    (pop && !empty),
        .o_rdata (w_out_rdata),
        .o_empty (empty),
        .o_count (w_out_count)
    );

    assign o_out = t_out_item'(w_out_rdata);

endmodule

@@ rtl/utgw_fifo.sv @@
// ----------------------------------------------------------------------------
// utgw_fifo
// Small register FIFO with show-ahead read and an occupancy count.
// ----------------------------------------------------------------------------
`include "ultrasonic_tcg_wall_gate_unit_macros.svh"

module utgw_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_wr,
    input  logic [WIDTH-1:0]             i_wdata,
    input  logic                         i_rd,
    output logic [WIDTH-1:0]             o_rdata,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (!i_wr && i_rd) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    assign o_rdata = r_mem[r_rd_ptr];
    assign o_empty = (r_count == '0);
    assign o_count = r_count;

    `UTGW_ASSERT(a_no_overflow, i_clk, i_rst_n, i_wr |-> (r_count < CNT_W'(DEPTH)))
    `UTGW_ASSERT(a_no_underflow, i_clk, i_rst_n, i_rd |-> !o_empty)
    `UTGW_ASSERT(a_count_holds, i_clk, i_rst_n, (!i_wr && !i_rd) |=> $stable(r_count))
    `UTGW_ASSERT_ALWAYS(a_reset_empty, i_clk, (!i_rst_n) |=> (r_count == '0))

endmodule

@@ rtl/utgw_front.sv @@
// ----------------------------------------------------------------------------
// utgw_front
// Takes items, writes the gain table, counts samples and elements, and
// fetches the gain of each sample into the middle queue.
// ----------------------------------------------------------------------------
module utgw_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_push,
    input  utgw_pkg::t_in_item                  i_in,
    input  logic [utgw_pkg::MID_CNT_W-1:0]      i_q_count,
    output logic                                o_full,
    output logic                                o_q_wr,
    output utgw_pkg::t_mid_item                 o_q_item
);
    import utgw_pkg::*;

    logic [GAIN_W-1:0]          r_gain_mem [MAX_SAMPLES];
    logic [SAMPLE_W-1:0]        r_sample_cnt;
    logic [ELEM_W-1:0]          r_elem_cnt;
    logic                       r_rd_valid;
    t_meta                      r_rd_meta;
    logic signed [AMP_BITS-1:0] r_rd_amp;
    logic [GAIN_W-1:0]          r_gain_q;

    logic                       n_accept;
    logic                       n_sample;
    logic                       n_gwrite;
    logic [MID_CNT_W:0]         n_used;

    // slot in the middle queue is reserved for the item in the fetch stage
    assign n_used   = (MID_CNT_W + 1)'(i_q_count) + (MID_CNT_W + 1)'(r_rd_valid);
    assign o_full   = (n_used >= (MID_CNT_W + 1)'(MID_DEPTH));
    assign n_accept = i_push && !o_full;
    assign n_sample = n_accept && (i_in.cmd == CMD_SAMPLE);
    assign n_gwrite = n_accept && (i_in.cmd == CMD_GAIN_WRITE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sample_cnt <= '0;
            r_elem_cnt   <= '0;
            r_rd_valid   <= 1'b0;
        end else begin
            r_rd_valid <= n_sample;
            if (n_sample) begin
                if (i_in.last_in_frame) begin
                    r_sample_cnt <= '0;
                    r_elem_cnt   <= '0;
                end else if (i_in.last_in_scan) begin
                    r_sample_cnt <= '0;
                    r_elem_cnt   <= (r_elem_cnt == ELEM_W'(MAX_ELEMENTS - 1)) ?
                                    '0 : r_elem_cnt + 1'b1;
                end else begin
                    r_sample_cnt <= (r_sample_cnt == SAMPLE_W'(MAX_SAMPLES - 1)) ?
                                    '0 : r_sample_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_gwrite) begin
            r_gain_mem[i_in.table_index] <= i_in.gain_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_sample) begin
            r_gain_q                <= r_gain_mem[r_sample_cnt];
            r_rd_amp                <= i_in.amplitude;
            r_rd_meta.element_index <= r_elem_cnt;
            r_rd_meta.sample_index  <= r_sample_cnt;
            r_rd_meta.scan_end      <= i_in.last_in_scan || i_in.last_in_frame;
        end
    end

    assign o_q_wr              = r_rd_valid;
    assign o_q_item.meta       = r_rd_meta;
    assign o_q_item.amplitude  = r_rd_amp;
    assign o_q_item.gain_value = r_gain_q;

endmodule

@@ rtl/utgw_back.sv @@
// ----------------------------------------------------------------------------
// utgw_back
// Gain, clip, normalize and saturate pipeline, followed by the front and
// back wall gate that keeps the per-scan gate state.
// ----------------------------------------------------------------------------
`include "ultrasonic_tcg_wall_gate_unit_macros.svh"

module utgw_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  utgw_pkg::t_cfg                      i_cfg,
    input  logic                                i_q_valid,
    input  utgw_pkg::t_mid_item                 i_q_item,
    output logic                                o_q_rd,
    input  logic [utgw_pkg::OUT_CNT_W-1:0]      i_out_count,
    output logic                                o_out_wr,
    output utgw_pkg::t_out_item                 o_out_item
);
    import utgw_pkg::*;

    localparam int P1_W = AMP_BITS + GAIN_W + 1;
    localparam int T_W  = P1_W - 16;
    localparam int P2_W = 16 + INV_W + 1;
    localparam int Q_W  = P2_W - 16;

    // stage 1: gain product
    logic                       r_s1_valid;
    t_meta                      r_s1_meta;
    logic signed [P1_W-1:0]     r_s1_prod;
    logic signed [AMP_BITS-1:0] r_s1_amp;
    logic                       r_s1_unity;
    // stage 2: truncate toward zero
    logic                       r_s2_valid;
    t_meta                      r_s2_meta;
    logic signed [T_W-1:0]      r_s2_t;
    logic signed [AMP_BITS-1:0] r_s2_amp;
    logic                       r_s2_unity;
    // stage 3: clipped amplitude (raw amplitude at unity gain)
    logic                       r_s3_valid;
    t_meta                      r_s3_meta;
    logic signed [15:0]         r_s3_amp;
    // stage 4: normalize product
    logic                       r_s4_valid;
    t_meta                      r_s4_meta;
    logic signed [P2_W-1:0]     r_s4_p2;
    // stage 5: saturated Q2.14
    logic                       r_s5_valid;
    t_meta                      r_s5_meta;
    logic signed [15:0]         r_s5_norm;
    // gate state
    logic                       r_front_found;
    logic                       r_back_found;
    logic [SAMPLE_W-1:0]        r_front_idx;

    logic signed [P1_W-1:0]     n_prod;
    logic signed [P1_W-1:0]     n_bias;
    logic signed [T_W-1:0]      n_lim;
    logic signed [T_W-1:0]      n_neg_lim;
    logic signed [15:0]         n_a3;
    logic signed [P2_W-1:0]     n_p2;
    logic signed [Q_W-1:0]      n_q;
    logic signed [15:0]         n_norm;
    logic [2:0]                 n_inflight;
    logic [OUT_CNT_W:0]         n_used;
    logic                       n_relative;
    logic                       n_front_hit;
    logic                       n_back_hit;
    logic [SAMPLE_W:0]          n_back_min;

    assign n_inflight = 3'(r_s1_valid) + 3'(r_s2_valid) + 3'(r_s3_valid)
                      + 3'(r_s4_valid) + 3'(r_s5_valid);
    assign n_used     = (OUT_CNT_W + 1)'(i_out_count) + (OUT_CNT_W + 1)'(n_inflight);
    assign o_q_rd     = i_q_valid && (n_used < (OUT_CNT_W + 1)'(OUT_DEPTH));

    assign n_prod = $signed(i_q_item.amplitude) * $signed({1'b0, i_q_item.gain_value});

    // bias negative products so the shift truncates toward zero
    assign n_bias    = r_s1_prod + (r_s1_prod[P1_W-1] ? P1_W'(65535) : P1_W'(0));
    assign n_lim     = $signed(T_W'(i_cfg.clip_limit));
    assign n_neg_lim = -n_lim;

    always_comb begin
        if (r_s2_unity) begin
            n_a3 = r_s2_amp;
        end else if (r_s2_t > n_lim) begin
            n_a3 = n_lim[15:0];
        end else if (r_s2_t < n_neg_lim) begin
            n_a3 = n_neg_lim[15:0];
        end else begin
            n_a3 = r_s2_t[15:0];
        end
    end

    assign n_p2 = r_s3_amp * $signed({1'b0, i_cfg.inv_full_scale});
    assign n_q  = r_s4_p2[P2_W-1:16];

    always_comb begin
        if (n_q > Q_W'(32767)) begin
            n_norm = 16'sh7FFF;
        end else if (n_q < -$signed(Q_W'(32768))) begin
            n_norm = 16'sh8000;
        end else begin
            n_norm = n_q[15:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s2_valid <= 1'b0;
            r_s3_valid <= 1'b0;
            r_s4_valid <= 1'b0;
            r_s5_valid <= 1'b0;
        end else begin
            r_s1_valid <= o_q_rd;
            r_s2_valid <= r_s1_valid;
            r_s3_valid <= r_s2_valid;
            r_s4_valid <= r_s3_valid;
            r_s5_valid <= r_s4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_meta  <= i_q_item.meta;
        r_s1_prod  <= n_prod;
        r_s1_amp   <= i_q_item.amplitude;
        r_s1_unity <= (i_q_item.gain_value == UNITY_GAIN);
        r_s2_meta  <= r_s1_meta;
        r_s2_t     <= n_bias[P1_W-1:16];
        r_s2_amp   <= r_s1_amp;
        r_s2_unity <= r_s1_unity;
        r_s3_meta  <= r_s2_meta;
        r_s3_amp   <= n_a3;
        r_s4_meta  <= r_s3_meta;
        r_s4_p2    <= n_p2;
        r_s5_meta  <= r_s4_meta;
        r_s5_norm  <= n_norm;
    end

    // wall gate
    assign n_relative  = i_cfg.gate_mode[MODE_RELATIVE];
    assign n_back_min  = (SAMPLE_W + 1)'(i_cfg.skip_samples) + (SAMPLE_W + 1)'(r_front_idx);
    assign n_front_hit = !r_front_found &&
                         (r_s5_norm > $signed({2'b00, i_cfg.front_threshold}));
    assign n_back_hit  = r_front_found && !r_back_found &&
                         (r_s5_meta.sample_index < i_cfg.max_depth_samples) &&
                         ((SAMPLE_W + 1)'(r_s5_meta.sample_index) > n_back_min) &&
                         (r_s5_norm > $signed({2'b00, i_cfg.back_threshold}));

    always_comb begin
        o_out_item.element_index  = r_s5_meta.element_index;
        o_out_item.sample_index   = r_s5_meta.sample_index;
        o_out_item.norm_amplitude = r_s5_norm;
        o_out_item.gate_kind      = GATE_NONE;
        o_out_item.gated_depth    = '0;
        if (n_front_hit) begin
            if (i_cfg.gate_mode[MODE_SHOW_FW]) begin
                o_out_item.gate_kind   = GATE_FRONT;
                o_out_item.gated_depth = n_relative ? '0 : r_s5_meta.sample_index;
            end
        end else if (n_back_hit) begin
            o_out_item.gate_kind   = GATE_BACK;
            o_out_item.gated_depth = n_relative ?
                                     (r_s5_meta.sample_index - r_front_idx) :
                                     r_s5_meta.sample_index;
        end
    end

    assign o_out_wr = r_s5_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front_found <= 1'b0;
            r_back_found  <= 1'b0;
            r_front_idx   <= '0;
        end else if (r_s5_valid) begin
            if (r_s5_meta.scan_end) begin
                r_front_found <= 1'b0;
                r_back_found  <= 1'b0;
                r_front_idx   <= '0;
            end else if (n_front_hit) begin
                r_front_found <= 1'b1;
                r_front_idx   <= r_s5_meta.sample_index;
            end else if (n_back_hit) begin
                r_back_found  <= 1'b1;
            end
        end
    end

    `UTGW_ASSERT(a_back_after_front, i_clk, i_rst_n, r_back_found |-> r_front_found)
    `UTGW_ASSERT(a_credit, i_clk, i_rst_n, n_used <= (OUT_CNT_W + 1)'(OUT_DEPTH))
    `UTGW_ASSERT(a_back_gate_src, i_clk, i_rst_n, (o_out_wr && (o_out_item.gate_kind == GATE_BACK)) |-> (r_front_found && !r_back_found))
    `UTGW_ASSERT(a_scan_end_clears, i_clk, i_rst_n, (r_s5_valid && r_s5_meta.scan_end) |=> (!r_front_found && !r_back_found))

endmodule
